// ----- hw/rtl/tpm_pkg.sv -----
// Shared constants, coefficient table and types of the 4x true-peak meter.
package tpm_pkg;

   localparam int PHASES   = 4;
   localparam int TAPS     = 12;
   localparam int HIST     = TAPS - 1;
   localparam int COEF_W   = 16;
   localparam int FRAC     = 15;
   localparam int ROUND    = 16384;
   localparam int OUT_W    = 26;
   localparam int PEAK_W   = 25;
   localparam int OUT_MAX  = 33554431;
   localparam int GROUP    = 4;
   localparam int GROUPS   = TAPS / GROUP;
   localparam int Q_DEPTH  = 4;
   localparam int PTR_W    = 2;
   localparam int CNT_W    = 3;

   // Q1.15 polyphase coefficients; tap 0 weights the newest sample
   localparam logic signed [COEF_W-1:0] COEF [PHASES][TAPS] = '{
      '{  16'sd56,   16'sd360,  -16'sd644,  16'sd1088, -16'sd1948,  16'sd4500,
          16'sd31856, -16'sd3352, 16'sd1560, -16'sd872,  16'sd488,  -16'sd272 },
      '{ -16'sd956,   16'sd960, -16'sd1696, 16'sd2920, -16'sd5456,  16'sd15240,
          16'sd25552, -16'sd6564, 16'sd3328, -16'sd1908, 16'sd1084, -16'sd620 },
      '{ -16'sd620,  16'sd1084, -16'sd1908, 16'sd3328, -16'sd6564,  16'sd25552,
          16'sd15240, -16'sd5456, 16'sd2920, -16'sd1696, 16'sd960,  -16'sd956 },
      '{ -16'sd272,   16'sd488,  -16'sd872, 16'sd1560, -16'sd3352,  16'sd31856,
          16'sd4500,  -16'sd1948, 16'sd1088, -16'sd644,  16'sd360,   16'sd56 }
   };

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ----- hw/rtl/tpm_front.sv -----
// Front end: accepts samples, keeps per-channel delay lines, forms filter windows.
module tpm_front #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   input  logic                     req_channel,
   input  logic                     req_start_block,
   input  logic                     req_clear_history,
   input  tpm_pkg::q_stat_type      q_stat,
   output logic                     push_valid,
   output logic [tpm_pkg::TAPS*SAMPLE_BITS+1:0] push_data
);

   localparam int SB    = SAMPLE_BITS;
   localparam int ROW_W = tpm_pkg::HIST * SB;
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [ROW_W-1:0] hist_ff [CHANNELS];
   logic             accept;
   logic             ch;
   logic [CH_W-1:0]  ch_idx;
   logic [ROW_W-1:0] row;
   logic [ROW_W-1:0] row_in;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   // channel number folded into range
   assign ch     = (CHANNELS > 1) ? req_channel : 1'b0;
   assign ch_idx = CH_W'(ch);

   // clear acts before filtering; the current sample still enters the line
   assign row    = req_clear_history ? '0 : hist_ff[ch_idx];
   assign row_in = {row[ROW_W-SB-1:0], req_sample};

   assign push_valid = accept;
   assign push_data  = {req_start_block, ch, row, req_sample};

   // delay line update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            hist_ff[c] <= '0;
         end
      end else if (accept) begin
         hist_ff[ch_idx] <= row_in;
      end
   end

endmodule

// ----- hw/rtl/tpm_queue.sv -----
// Short queue decoupling the front end from the filter pipeline.
module tpm_queue #(
   parameter int WIDTH = 290
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     pop_data,
   output tpm_pkg::q_stat_type  q_stat
);

   logic [WIDTH-1:0]              mem_ff [tpm_pkg::Q_DEPTH];
   logic [tpm_pkg::PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tpm_pkg::PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tpm_pkg::CNT_W-1:0]     cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == tpm_pkg::CNT_W'(tpm_pkg::Q_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/tpm_back.sv -----
// Back end: four-phase FIR pipeline, rounding, saturation and peak tracking.
module tpm_back #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tpm_pkg::q_stat_type                   q_stat,
   input  logic [tpm_pkg::TAPS*SAMPLE_BITS+1:0]  pop_data,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_out_channel,
   output logic signed [tpm_pkg::OUT_W-1:0]      rsp_phase_zero,
   output logic signed [tpm_pkg::OUT_W-1:0]      rsp_phase_one,
   output logic signed [tpm_pkg::OUT_W-1:0]      rsp_phase_two,
   output logic signed [tpm_pkg::OUT_W-1:0]      rsp_phase_three,
   output logic [tpm_pkg::PEAK_W-1:0]            rsp_peak
);

   localparam int SB     = SAMPLE_BITS;
   localparam int PW     = SB + tpm_pkg::COEF_W;
   localparam int GW     = PW + 2;
   localparam int ACC_W  = SB + 21;
   localparam int WIN_W  = tpm_pkg::TAPS * SB;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PHASES = tpm_pkg::PHASES;
   localparam int OW     = tpm_pkg::OUT_W;
   localparam int KW     = tpm_pkg::PEAK_W;
   localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(tpm_pkg::OUT_MAX);
   localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

   logic adv;

   // stage 1: coefficient products
   logic                 v1_ff, ch1_ff, st1_ff;
   logic signed [PW-1:0] prod_ff [PHASES][tpm_pkg::TAPS];
   logic signed [PW-1:0] prod_in [PHASES][tpm_pkg::TAPS];
   logic [WIN_W-1:0]     win;

   // stage 2: partial sums
   logic                 v2_ff, ch2_ff, st2_ff;
   logic signed [GW-1:0] psum_ff [PHASES][tpm_pkg::GROUPS];
   logic signed [GW-1:0] psum_in [PHASES][tpm_pkg::GROUPS];

   // stage 3: rounded, saturated phase values
   logic                 v3_ff, ch3_ff, st3_ff;
   logic signed [OW-1:0] y_ff [PHASES];
   logic signed [OW-1:0] y_in [PHASES];

   // stage 4: output register and peaks
   logic                 rsp_valid_ff;
   logic                 rsp_ch_ff;
   logic signed [OW-1:0] rsp_y_ff [PHASES];
   logic [KW-1:0]        rsp_peak_ff;
   logic [KW-1:0]        peak_ff [CHANNELS];
   logic [KW-1:0]        peak_in;
   logic [CH_W-1:0]      ch3_idx;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !q_stat.empty;
   assign win = pop_data[WIN_W-1:0];

   always_comb begin
      for (int p = 0; p < PHASES; p++) begin
         for (int k = 0; k < tpm_pkg::TAPS; k++) begin
            prod_in[p][k] = PW'($signed(win[k*SB +: SB])) * PW'(tpm_pkg::COEF[p][k]);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < PHASES; p++) begin
         for (int g = 0; g < tpm_pkg::GROUPS; g++) begin
            psum_in[p][g] = GW'(prod_ff[p][g*tpm_pkg::GROUP])
                          + GW'(prod_ff[p][g*tpm_pkg::GROUP+1])
                          + GW'(prod_ff[p][g*tpm_pkg::GROUP+2])
                          + GW'(prod_ff[p][g*tpm_pkg::GROUP+3]);
         end
      end
   end

   // round to nearest (ties up), drop 15 fraction bits, clamp to output range
   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] yv;
      for (int p = 0; p < PHASES; p++) begin
         acc = ACC_W'(tpm_pkg::ROUND);
         for (int g = 0; g < tpm_pkg::GROUPS; g++) begin
            acc = acc + ACC_W'(psum_ff[p][g]);
         end
         yv = acc >>> tpm_pkg::FRAC;
         if (yv > Y_MAX) begin
            yv = Y_MAX;
         end else if (yv < Y_MIN) begin
            yv = Y_MIN;
         end
         y_in[p] = OW'(yv);
      end
   end

   // magnitudes and running peak; start clears before this sample counts
   assign ch3_idx = CH_W'(ch3_ff);
   always_comb begin
      logic [OW-1:0] mag;
      logic [KW-1:0] mag_c;
      peak_in = st3_ff ? '0 : peak_ff[ch3_idx];
      for (int p = 0; p < PHASES; p++) begin
         mag   = y_ff[p][OW-1] ? (~y_ff[p] + 1'b1) : y_ff[p];
         mag_c = mag[OW-1] ? '1 : mag[KW-1:0];
         if (mag_c > peak_in) begin
            peak_in = mag_c;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= !q_stat.empty;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   // per-channel peak state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            peak_ff[c] <= '0;
         end
      end else if (adv && v3_ff) begin
         peak_ff[ch3_idx] <= peak_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff      <= pop_data[WIN_W+1];
         ch1_ff      <= pop_data[WIN_W];
         prod_ff     <= prod_in;
         st2_ff      <= st1_ff;
         ch2_ff      <= ch1_ff;
         psum_ff     <= psum_in;
         st3_ff      <= st2_ff;
         ch3_ff      <= ch2_ff;
         y_ff        <= y_in;
         rsp_ch_ff   <= ch3_ff;
         rsp_y_ff    <= y_ff;
         rsp_peak_ff <= peak_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_phase_zero  = rsp_y_ff[0];
   assign rsp_phase_one   = rsp_y_ff[1];
   assign rsp_phase_two   = rsp_y_ff[2];
   assign rsp_phase_three = rsp_y_ff[3];
   assign rsp_peak        = rsp_peak_ff;

endmodule

// ----- hw/rtl/true_peak_meter_4x.sv -----
// Top level of the 4x oversampling true-peak meter.
// A result beat passes the queue and the product, partial-sum, phase and
// output registers. Throughput: one sample per cycle unless the receiver
// stalls; the four-stage filter pipeline and per-channel peak update set it.
// Reset (synchronous, active high) zeroes all delay lines and channel peaks,
// empties the queue and pipeline; the block accepts samples the next cycle.
module true_peak_meter_4x #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_sample,
   input  logic                              req_channel,
   input  logic                              req_start_block,
   input  logic                              req_clear_history,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_out_channel,
   output logic signed [tpm_pkg::OUT_W-1:0]  rsp_phase_zero,
   output logic signed [tpm_pkg::OUT_W-1:0]  rsp_phase_one,
   output logic signed [tpm_pkg::OUT_W-1:0]  rsp_phase_two,
   output logic signed [tpm_pkg::OUT_W-1:0]  rsp_phase_three,
   output logic [tpm_pkg::PEAK_W-1:0]        rsp_peak
);

   localparam int DW = tpm_pkg::TAPS * SAMPLE_BITS + 2;

   tpm_pkg::q_stat_type q_stat;
   logic                push_valid;
   logic [DW-1:0]       push_data;
   logic                pop;
   logic [DW-1:0]       pop_data;

   tpm_front #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_channel       (req_channel),
      .req_start_block   (req_start_block),
      .req_clear_history (req_clear_history),
      .q_stat            (q_stat),
      .push_valid        (push_valid),
      .push_data         (push_data)
   );

   tpm_queue #(
      .WIDTH (DW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   tpm_back #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_phase_zero  (rsp_phase_zero),
      .rsp_phase_one   (rsp_phase_one),
      .rsp_phase_two   (rsp_phase_two),
      .rsp_phase_three (rsp_phase_three),
      .rsp_peak        (rsp_peak)
   );

endmodule

// ----- hw/rtl/tpm_checker.sv -----
// Port-level checker for the true-peak meter and its bind.
module tpm_checker #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [SAMPLE_BITS-1:0]            req_sample,
   input logic                              req_channel,
   input logic                              req_start_block,
   input logic                              req_clear_history,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_out_channel,
   input logic signed [tpm_pkg::OUT_W-1:0]  rsp_phase_zero,
   input logic signed [tpm_pkg::OUT_W-1:0]  rsp_phase_one,
   input logic signed [tpm_pkg::OUT_W-1:0]  rsp_phase_two,
   input logic signed [tpm_pkg::OUT_W-1:0]  rsp_phase_three,
   input logic [tpm_pkg::PEAK_W-1:0]        rsp_peak
);

   localparam int OW = tpm_pkg::OUT_W;

   logic [OW-1:0] m0, m1, m2, m3;
   logic          peak_ok;

   // magnitudes of the reported phases
   assign m0 = rsp_phase_zero[OW-1]  ? (~rsp_phase_zero + 1'b1)  : rsp_phase_zero;
   assign m1 = rsp_phase_one[OW-1]   ? (~rsp_phase_one + 1'b1)   : rsp_phase_one;
   assign m2 = rsp_phase_two[OW-1]   ? (~rsp_phase_two + 1'b1)   : rsp_phase_two;
   assign m3 = rsp_phase_three[OW-1] ? (~rsp_phase_three + 1'b1) : rsp_phase_three;

   // peak covers every phase of its own beat (saturated at full peak range)
   assign peak_ok = (rsp_peak == '1)
                 || ((OW'(rsp_peak) >= m0) && (OW'(rsp_peak) >= m1)
                  && (OW'(rsp_peak) >= m2) && (OW'(rsp_peak) >= m3));

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_peak)
         && $stable(rsp_phase_zero) && $stable(rsp_out_channel))
      else $error("stalled result beat changed");

   // a stalled sample beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_sample)
         && $stable(req_channel) && $stable(req_start_block)
         && $stable(req_clear_history))
      else $error("stalled sample beat changed");

   // peak never below a phase magnitude of the same beat
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> peak_ok)
      else $error("peak below phase magnitude");

   // single-channel build reports channel zero only
   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CHANNELS > 1) || (rsp_out_channel == 1'b0))
      else $error("result channel out of range");

endmodule

bind true_peak_meter_4x tpm_checker #(
   .CHANNELS    (CHANNELS),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_tpm_checker (.*);

// ----- tb/sv/true_peak_meter_4x_test.sv -----
// Self-checking testbench for the 4x oversampling true-peak meter.
`timescale 1ns / 1ps

module true_peak_meter_4x_test;

   localparam int SBITS       = 24;
   localparam int NPHASE      = 4;
   localparam int NTAP        = 12;
   localparam int NHIST       = NTAP - 1;
   localparam int NCHAN       = 2;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN       = 20;
   localparam int LIMIT       = 400000;
   localparam longint PH_MAX  = 33554431;
   localparam longint PH_MIN  = -33554432;

   // Q1.15 interpolation weights, tap 0 on the newest sample
   localparam int TAP_WEIGHT [NPHASE][NTAP] = '{
      '{   56,   360,  -644,  1088, -1948,  4500, 31856, -3352,  1560,  -872,   488,  -272 },
      '{ -956,   960, -1696,  2920, -5456, 15240, 25552, -6564,  3328, -1908,  1084,  -620 },
      '{ -620,  1084, -1908,  3328, -6564, 25552, 15240, -5456,  2920, -1696,   960,  -956 },
      '{ -272,   488,  -872,  1560, -3352, 31856,  4500, -1948,  1088,  -644,   360,    56 }
   };

   typedef struct packed {
      logic [SBITS-1:0] sample;
      logic             channel;
      logic             start_block;
      logic             clear_history;
   } sample_beat_type;

   typedef struct packed {
      logic                          channel;
      logic [NPHASE-1:0][tpm_pkg::OUT_W-1:0] phase;
      logic [tpm_pkg::PEAK_W-1:0]    peak;
   } meter_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [SBITS-1:0]                 req_sample = '0;
   logic                             req_channel = 1'b0;
   logic                             req_start_block = 1'b0;
   logic                             req_clear_history = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_out_channel;
   logic signed [tpm_pkg::OUT_W-1:0] rsp_phase_zero;
   logic signed [tpm_pkg::OUT_W-1:0] rsp_phase_one;
   logic signed [tpm_pkg::OUT_W-1:0] rsp_phase_two;
   logic signed [tpm_pkg::OUT_W-1:0] rsp_phase_three;
   logic [tpm_pkg::PEAK_W-1:0]       rsp_peak;

   // predictor state: delay lines and running peaks
   logic signed [SBITS-1:0]    delay_line [NCHAN][NHIST];
   logic [tpm_pkg::PEAK_W-1:0] chan_peak  [NCHAN];

   sample_beat_type  sample_q[$];
   meter_result_type peak_expect_q[$];

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   logic hold_req = 1'b0;
   logic hold_taken = 1'b0;
   int  hold_left = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;

   true_peak_meter_4x #(
      .CHANNELS    (NCHAN),
      .SAMPLE_BITS (SBITS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_channel       (req_channel),
      .req_start_block   (req_start_block),
      .req_clear_history (req_clear_history),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_phase_zero    (rsp_phase_zero),
      .rsp_phase_one     (rsp_phase_one),
      .rsp_phase_two     (rsp_phase_two),
      .rsp_phase_three   (rsp_phase_three),
      .rsp_peak          (rsp_peak)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Filter one sample against its channel history; updates peak and history.
   function automatic meter_result_type oversample_beat(logic [SBITS-1:0] smp, logic chn,
                                                        logic start, logic clr);
      meter_result_type res;
      longint x;
      longint acc;
      longint y;
      longint mag;
      int ch;
      ch = int'(chn) % NCHAN;
      x = longint'($signed(smp));
      if (clr)
         for (int k = 0; k < NHIST; k++) delay_line[ch][k] = '0;
      if (start)
         chan_peak[ch] = '0;
      res.channel = ch[0];
      for (int p = 0; p < NPHASE; p++) begin
         acc = longint'(TAP_WEIGHT[p][0]) * x;
         for (int k = 1; k < NTAP; k++)
            acc += longint'(TAP_WEIGHT[p][k]) * longint'(delay_line[ch][k-1]);
         // round to nearest, ties up: floor((acc + 2^14) / 2^15)
         y = (acc + 64'sd16384) >>> 15;
         if (y > PH_MAX) y = PH_MAX;
         if (y < PH_MIN) y = PH_MIN;
         mag = (y < 0) ? -y : y;
         if (mag > PH_MAX) mag = PH_MAX;
         if (mag > longint'(chan_peak[ch]))
            chan_peak[ch] = mag[tpm_pkg::PEAK_W-1:0];
         res.phase[p] = y[tpm_pkg::OUT_W-1:0];
      end
      res.peak = chan_peak[ch];
      for (int k = NHIST - 1; k > 0; k--)
         delay_line[ch][k] = delay_line[ch][k-1];
      delay_line[ch][0] = smp;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      mismatch_count++;
      $display("tb: mismatch on %s at cycle %0d: got %0d, expected %0d",
               field, cycle_count, got, want);
   endtask

   task automatic queue_sample(input logic [SBITS-1:0] s, input logic c,
                               input logic st, input logic cl);
      sample_beat_type b;
      b.sample = s;
      b.channel = c;
      b.start_block = st;
      b.clear_history = cl;
      sample_q.push_back(b);
   endtask

   // Random runs of a few styles: full range, near-Nyquist large tones that
   // overshoot between samples, small values and the extremes.
   task automatic queue_random_items(input int count);
      int left;
      int run;
      int style;
      int amp;
      int period;
      logic chn;
      logic fixed_chan;
      logic [SBITS-1:0] s;
      left = count;
      while (left > 0) begin
         run = $urandom_range(40, 6);
         if (run > left) run = left;
         style = $urandom_range(99);
         amp = $urandom_range(8388607, 5000000);
         period = $urandom_range(3, 1);
         fixed_chan = 1'($urandom_range(1));
         chn = 1'($urandom_range(1));
         for (int i = 0; i < run; i++) begin
            if (style < 40) begin
               s = SBITS'($urandom());
            end else if (style < 70) begin
               s = ((i / period) % 2 == 0) ? SBITS'(amp) : SBITS'(-amp - $urandom_range(1));
            end else if (style < 88) begin
               s = SBITS'(int'($urandom_range(1023)) - 512);
            end else begin
               case ($urandom_range(4))
                  0: s = 24'h7FFFFF;
                  1: s = 24'h800000;
                  2: s = 24'h000000;
                  3: s = 24'h000001;
                  default: s = 24'hFFFFFF;
               endcase
            end
            if (!fixed_chan) chn = 1'($urandom_range(1));
            queue_sample(s, chn, ($urandom_range(11) == 0), ($urandom_range(19) == 0));
         end
         left -= run;
      end
   endtask

   // wait at a falling edge until every queued beat has come back
   task automatic wait_drained();
      while (sample_q.size() != 0 || req_valid || peak_expect_q.size() != 0)
         @(negedge clock);
   endtask

   // Driver: predict each accepted beat, then offer the next one.
   always @(posedge clock) begin : drive
      sample_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            peak_expect_q.push_back(oversample_beat(req_sample, req_channel,
                                                    req_start_block, req_clear_history));
         if (!req_valid || !req_stall) begin
            if (sample_q.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
               nxt = sample_q.pop_front();
               req_valid         <= 1'b1;
               req_sample        <= nxt.sample;
               req_channel       <= nxt.channel;
               req_start_block   <= nxt.start_block;
               req_clear_history <= nxt.clear_history;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall, with one long hold-off counted here
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (int'($urandom_range(99)) < rsp_stall_pct);
      end
   end

   // Monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin : watch
      meter_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (peak_expect_q.size() == 0) begin
            report_mismatch("unexpected result beat, channel", rsp_out_channel, -1);
         end else begin
            want = peak_expect_q.pop_front();
            if (rsp_out_channel !== want.channel)
               report_mismatch("out_channel", rsp_out_channel, want.channel);
            if (rsp_phase_zero !== want.phase[0])
               report_mismatch("phase_zero", rsp_phase_zero, $signed(want.phase[0]));
            if (rsp_phase_one !== want.phase[1])
               report_mismatch("phase_one", rsp_phase_one, $signed(want.phase[1]));
            if (rsp_phase_two !== want.phase[2])
               report_mismatch("phase_two", rsp_phase_two, $signed(want.phase[2]));
            if (rsp_phase_three !== want.phase[3])
               report_mismatch("phase_three", rsp_phase_three, $signed(want.phase[3]));
            if (rsp_peak !== want.peak)
               report_mismatch("peak", rsp_peak, want.peak);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      for (int c = 0; c < NCHAN; c++) begin
         chan_peak[c] = '0;
         for (int k = 0; k < NHIST; k++) delay_line[c][k] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, flags alone and together, full-scale overshoot
      queue_sample(24'h7FFFFF, 1'b0, 1'b1, 1'b1);
      queue_sample(24'h800000, 1'b0, 1'b0, 1'b0);
      queue_sample(24'h7FFFFF, 1'b0, 1'b0, 1'b0);
      queue_sample(24'h800000, 1'b0, 1'b0, 1'b0);
      queue_sample(24'h7FFFFF, 1'b0, 1'b0, 1'b0);
      queue_sample(24'h800000, 1'b1, 1'b1, 1'b0);
      queue_sample(24'h000000, 1'b1, 1'b0, 1'b0);
      queue_sample(24'h000001, 1'b1, 1'b0, 1'b0);
      queue_sample(24'hFFFFFF, 1'b1, 1'b0, 1'b0);
      queue_sample(24'h000010, 1'b0, 1'b1, 1'b0);
      queue_sample(24'h123456, 1'b0, 1'b0, 1'b1);
      queue_sample(24'h7FFFFF, 1'b1, 1'b1, 1'b1);
      for (int i = 0; i < 11; i++)
         queue_sample(24'h7FFFFF, 1'b1, 1'b0, 1'b0);
      queue_sample(24'h800000, 1'b0, 1'b1, 1'b1);
      queue_sample(24'h800000, 1'b0, 1'b0, 1'b0);
      wait_drained();

      // no idling
      queue_random_items(250);
      wait_drained();

      // sender idles
      send_idle_pct <= 76;
      rsp_stall_pct <= 0;
      queue_random_items(300);
      wait_drained();

      // receiver stalls
      send_idle_pct <= 0;
      rsp_stall_pct <= 76;
      queue_random_items(300);
      wait_drained();

      // both sides idle
      send_idle_pct <= 24;
      rsp_stall_pct <= 24;
      queue_random_items(300);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      send_idle_pct <= 0;
      rsp_stall_pct <= 0;
      hold_req <= 1'b1;
      queue_random_items(200);
      wait_drained();

      repeat (DRAIN) @(posedge clock);
      if (mismatch_count == 0 && peak_expect_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
